/* rtl/xxh_pkg.sv */
package xxh_pkg;

  localparam logic [63:0] Prime1 = 64'h9E37_79B1_85EB_CA87;
  localparam logic [63:0] Prime2 = 64'hC2B2_AE3D_27D4_EB4F;
  localparam logic [63:0] Prime3 = 64'h1656_67B1_9E37_79F9;
  localparam logic [63:0] Prime4 = 64'h85EB_CA77_C2B2_AE63;
  localparam logic [63:0] Prime5 = 64'h27D4_EB2F_1656_67C5;

  localparam logic [3:0][63:0] LaneInit = {
    64'h0 - Prime1, 64'h0, Prime2, Prime1 + Prime2
  };

  localparam int unsigned WordBytes = 8;
  localparam int unsigned DefQueueDepth = 2;
  localparam logic [3:0] FullWord = 4'(WordBytes);

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FIN,
    S_LEN,
    S_LAST,
    S_AVS,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_LANE_A,
    OP_LANE_B,
    OP_MG_A,
    OP_MG_B,
    OP_MG_C,
    OP_FD_A,
    OP_FD_B,
    OP_FD_C,
    OP_W4_A,
    OP_W4_B,
    OP_B1_A,
    OP_B1_B,
    OP_AV_A,
    OP_AV_B
  } op_e;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (64 - s));
  endfunction

endpackage

/* rtl/xxhash64_stream_hasher_top.sv */
// a word that does not close a stripe is stored in S_IDLE; a word that closes one starts the stripe update
// (eight 64-bit multiplies, run in turn on one shared 32x32 multiplier)
// last word: up to 31 multiplies for merge, tail and avalanche
// throughput: one word per cycle between stripes, stalls during stripe and finish
// reset: asynchronous active low, lanes return to their initial values, queue empty
module xxhash64_stream_hasher_top #(
  parameter int unsigned QueueDepth = xxh_pkg::DefQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);
  import xxh_pkg::*;

  item_t item;
  logic  item_valid, pop;

  xxh_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  xxh_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

endmodule

/* rtl/xxh_front.sv */
module xxh_front #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [63:0]    data_word_i,
  input  logic [3:0]     byte_count_i,
  input  logic           last_word_i,
  input  logic           pop_i,
  output logic           item_valid_o,
  output xxh_pkg::item_t item_o
);
  import xxh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  item_t            in_item;
  logic             push, pop;

  always_comb begin
    in_item.data = data_word_i;
    in_item.last = last_word_i;
    if (!last_word_i || byte_count_i > FullWord) begin
      in_item.nbytes = FullWord;
    end else begin
      in_item.nbytes = byte_count_i;
    end
  end

  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop lost");

endmodule

/* rtl/xxh_mul.sv */
module xxh_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import xxh_pkg::*;

  logic [63:0] a_q, b_q, m_q, acc_q;
  logic [2:0]  cnt_q;
  logic [31:0] ma, mb;

  always_comb begin
    case (cnt_q)
      3'd1:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
      3'd2:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
      default: begin ma = a_q[63:32]; mb = b_q[31:0];  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    m_q <= 64'(ma) * 64'(mb);
    case (cnt_q)
      3'd2:    acc_q <= m_q;
      3'd3:    acc_q <= acc_q + {m_q[31:0], 32'h0};
      3'd4:    acc_q <= acc_q + {m_q[31:0], 32'h0};
      default: acc_q <= acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 3'd1;
    end else if (cnt_q == 3'd5) begin
      cnt_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign done_o = (cnt_q == 3'd5);
  assign p_o    = acc_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o) else $error("multiply latency");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !start_i) else $error("multiply restarted while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

endmodule

/* rtl/xxh_engine.sv */
module xxh_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  xxh_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [63:0]    hash_value_o
);
  import xxh_pkg::*;

  state_e      state_q, state_d;
  op_e         op_q, op_d;
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] buf_q [4];
  logic [63:0] buf_d [4];
  logic [1:0]  pos_q, pos_d, k_q, k_d;
  logic [63:0] len_q, len_d, w_q, w_d, h_q, h_d, x_q, x_d, res_q, res_d;
  logic        seen_q, seen_d, fin_q, fin_d, flast_q, flast_d, ovalid_q, ovalid_d;
  logic [2:0]  b_q, b_d;
  logic [3:0]  n_q, n_d;
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, p;
  logic [63:0] fsrc;

  xxh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (p)
  );

  assign fsrc = flast_q ? w_q : buf_q[k_q];

  always_comb begin
    mul_a = h_q;
    mul_b = Prime1;
    unique case (op_q)
      OP_LANE_A: begin mul_a = buf_q[k_q];  mul_b = Prime2; end
      OP_LANE_B: begin mul_a = x_q;         mul_b = Prime1; end
      OP_MG_A:   begin mul_a = lane_q[k_q]; mul_b = Prime2; end
      OP_MG_B:   begin mul_a = x_q;         mul_b = Prime1; end
      OP_MG_C:   begin mul_a = h_q;         mul_b = Prime1; end
      OP_FD_A:   begin mul_a = fsrc;        mul_b = Prime2; end
      OP_FD_B:   begin mul_a = x_q;         mul_b = Prime1; end
      OP_FD_C:   begin mul_a = h_q;         mul_b = Prime1; end
      OP_W4_A:   begin mul_a = {32'h0, w_q[31:0]}; mul_b = Prime1; end
      OP_W4_B:   begin mul_a = h_q;         mul_b = Prime2; end
      OP_B1_A:   begin mul_a = {56'h0, w_q[{b_q, 3'b000} +: 8]}; mul_b = Prime5; end
      OP_B1_B:   begin mul_a = h_q;         mul_b = Prime1; end
      OP_AV_A:   begin mul_a = h_q;         mul_b = Prime2; end
      OP_AV_B:   begin mul_a = h_q;         mul_b = Prime3; end
      default:   begin mul_a = h_q;         mul_b = Prime1; end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    lane_d    = lane_q;
    buf_d     = buf_q;
    pos_d     = pos_q;
    k_d       = k_q;
    len_d     = len_q;
    w_d       = w_q;
    h_d       = h_q;
    x_d       = x_q;
    res_d     = res_q;
    seen_d    = seen_q;
    fin_d     = fin_q;
    flast_d   = flast_q;
    b_d       = b_q;
    n_d       = n_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    pop_o     = 1'b0;
    mul_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (!item_i.last) begin
            buf_d[pos_q] = item_i.data;
            len_d = len_q + 64'(WordBytes);
            if (pos_q == 2'd3) begin
              k_d = '0;
              op_d = OP_LANE_A;
              state_d = S_ISSUE;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end else begin
            len_d = len_q + 64'(item_i.nbytes);
            w_d   = item_i.data;
            n_d   = item_i.nbytes;
            fin_d = 1'b1;
            if (item_i.nbytes == FullWord && pos_q == 2'd3) begin
              buf_d[3] = item_i.data;
              n_d = '0;
              k_d = '0;
              op_d = OP_LANE_A;
              state_d = S_ISSUE;
            end else begin
              state_d = S_FIN;
            end
          end
        end
      end
      S_ISSUE: begin
        mul_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mul_done) begin
          state_d = S_ISSUE;
          unique case (op_q)
            OP_LANE_A: begin
              x_d  = rotl(lane_q[k_q] + p, 31);
              op_d = OP_LANE_B;
            end
            OP_LANE_B: begin
              lane_d[k_q] = p;
              if (k_q == 2'd3) begin
                k_d = '0;
                pos_d = '0;
                seen_d = 1'b1;
                state_d = fin_q ? S_FIN : S_IDLE;
              end else begin
                k_d = k_q + 1'b1;
                op_d = OP_LANE_A;
              end
            end
            OP_MG_A: begin
              x_d  = rotl(p, 31);
              op_d = OP_MG_B;
            end
            OP_MG_B: begin
              h_d  = h_q ^ p;
              op_d = OP_MG_C;
            end
            OP_MG_C: begin
              h_d = p + Prime4;
              if (k_q == 2'd3) begin
                k_d = '0;
                state_d = S_LEN;
              end else begin
                k_d = k_q + 1'b1;
                op_d = OP_MG_A;
              end
            end
            OP_FD_A: begin
              x_d  = rotl(p, 31);
              op_d = OP_FD_B;
            end
            OP_FD_B: begin
              h_d  = rotl(h_q ^ p, 27);
              op_d = OP_FD_C;
            end
            OP_FD_C: begin
              h_d = p + Prime4;
              if (flast_q) begin
                state_d = S_AVS;
              end else if ({1'b0, k_q} + 3'd1 == {1'b0, pos_q}) begin
                state_d = S_LAST;
              end else begin
                k_d = k_q + 1'b1;
                op_d = OP_FD_A;
              end
            end
            OP_W4_A: begin
              h_d  = rotl(h_q ^ p, 23);
              op_d = OP_W4_B;
            end
            OP_W4_B: begin
              h_d = p + Prime3;
              b_d = 3'd4;
              if (n_q > 4'd4) begin
                op_d = OP_B1_A;
              end else begin
                state_d = S_AVS;
              end
            end
            OP_B1_A: begin
              h_d  = rotl(h_q ^ p, 11);
              op_d = OP_B1_B;
            end
            OP_B1_B: begin
              h_d = p;
              b_d = b_q + 1'b1;
              if ({1'b0, b_q} + 4'd1 == n_q) begin
                state_d = S_AVS;
              end else begin
                op_d = OP_B1_A;
              end
            end
            OP_AV_A: begin
              h_d  = p ^ (p >> 29);
              op_d = OP_AV_B;
            end
            OP_AV_B: begin
              h_d = p ^ (p >> 32);
              state_d = S_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FIN: begin
        k_d = '0;
        if (seen_q) begin
          h_d = rotl(lane_q[0], 1) + rotl(lane_q[1], 7) +
                rotl(lane_q[2], 12) + rotl(lane_q[3], 18);
          op_d = OP_MG_A;
          state_d = S_ISSUE;
        end else begin
          h_d = Prime5;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        h_d = h_q + len_q;
        k_d = '0;
        if (pos_q != '0) begin
          op_d = OP_FD_A;
          state_d = S_ISSUE;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        b_d = '0;
        if (n_q == FullWord) begin
          flast_d = 1'b1;
          op_d = OP_FD_A;
          state_d = S_ISSUE;
        end else if (n_q >= 4'd4) begin
          op_d = OP_W4_A;
          state_d = S_ISSUE;
        end else if (n_q != '0) begin
          op_d = OP_B1_A;
          state_d = S_ISSUE;
        end else begin
          state_d = S_AVS;
        end
      end
      S_AVS: begin
        h_d = h_q ^ (h_q >> 33);
        op_d = OP_AV_A;
        state_d = S_ISSUE;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          res_d    = h_q;
          ovalid_d = 1'b1;
          for (int i = 0; i < 4; i++) begin
            lane_d[i] = LaneInit[i];
          end
          pos_d   = '0;
          len_d   = '0;
          seen_d  = 1'b0;
          fin_d   = 1'b0;
          flast_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    w_q   <= w_d;
    h_q   <= h_d;
    x_q   <= x_d;
    res_q <= res_d;
    k_q   <= k_d;
    b_q   <= b_d;
    n_q   <= n_d;
    op_q  <= op_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= LaneInit[i];
      end
      pos_q    <= '0;
      len_q    <= '0;
      seen_q   <= 1'b0;
      fin_q    <= 1'b0;
      flast_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lane_q   <= lane_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
      fin_q    <= fin_d;
      flast_q  <= flast_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign hash_value_o = res_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("item taken while busy");
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |=> (pos_q == '0 && len_q == '0 && !seen_q))
    else $error("message state not cleared");
  a_start_in_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> state_q == S_WAIT) else $error("multiply not awaited");

endmodule

/* verif/xxhash64_stream_hasher_top_tb.sv */
module xxhash64_stream_hasher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xxh_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] hash_value_o;

  xxhash64_stream_hasher_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_word_i,
    .byte_count_i,
    .last_word_i,
    .out_valid_o,
    .out_ready_i,
    .hash_value_o
  );

  always #2 clk_i = ~clk_i;

  // hash model state
  logic [3:0][63:0] lanes;
  logic [3:0][63:0] stripe_words;
  int unsigned      words_held;
  logic [63:0]      msg_length;
  bit               stripe_done;

  logic [63:0] hash_queue[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  function automatic logic [63:0] rot_left(logic [63:0] v, int unsigned s);
    return (s == 0) ? v : ((v << s) | (v >> (64 - s)));
  endfunction

  function automatic logic [63:0] lane_round(logic [63:0] acc, logic [63:0] w);
    acc = acc + w * Prime2;
    return rot_left(acc, 31) * Prime1;
  endfunction

  function automatic logic [63:0] fold_word(logic [63:0] h, logic [63:0] w);
    h ^= lane_round(64'h0, w);
    return rot_left(h, 27) * Prime1 + Prime4;
  endfunction

  task automatic clear_msg();
    lanes = LaneInit;
    words_held = 0;
    msg_length = '0;
    stripe_done = 0;
  endtask

  task automatic absorb_word(logic [63:0] w);
    stripe_words[words_held] = w;
    words_held++;
    if (words_held == 4) begin
      for (int i = 0; i < 4; i++) lanes[i] = lane_round(lanes[i], stripe_words[i]);
      words_held = 0;
      stripe_done = 1;
    end
  endtask

  function automatic logic [63:0] final_hash(logic [63:0] w, int unsigned n);
    logic [63:0] h;
    int unsigned b;
    if (stripe_done) begin
      h = rot_left(lanes[0], 1) + rot_left(lanes[1], 7) + rot_left(lanes[2], 12)
          + rot_left(lanes[3], 18);
      for (int i = 0; i < 4; i++) begin
        h ^= lane_round(64'h0, lanes[i]);
        h = h * Prime1 + Prime4;
      end
    end else begin
      h = Prime5;
    end
    h += msg_length;
    for (int i = 0; i < words_held; i++) h = fold_word(h, stripe_words[i]);
    if (n == 8) begin
      h = fold_word(h, w);
    end else begin
      b = 0;
      if (n >= 4) begin
        h ^= {32'h0, w[31:0]} * Prime1;
        h = rot_left(h, 23) * Prime2 + Prime3;
        b = 4;
      end
      for (; b < n; b++) begin
        h ^= {56'h0, w[8*b +: 8]} * Prime5;
        h = rot_left(h, 11) * Prime1;
      end
    end
    h ^= h >> 33;
    h *= Prime2;
    h ^= h >> 29;
    h *= Prime3;
    h ^= h >> 32;
    return h;
  endfunction

  task automatic predict_word(logic [63:0] w, logic [3:0] cnt, logic lst);
    int unsigned n;
    if (!lst) begin
      msg_length += 8;
      absorb_word(w);
    end else begin
      n = (cnt > 8) ? 8 : cnt;
      msg_length += n;
      if (n == 8 && words_held == 3) begin
        absorb_word(w);
        n = 0;
        w = '0;
      end
      hash_queue.push_back(final_hash(w, n));
      clear_msg();
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(logic [63:0] w, logic [3:0] cnt, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_word_i <= w;
    byte_count_i <= cnt;
    last_word_i <= lst;
    predict_word(w, cnt, lst);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_message(int unsigned nwords, logic [3:0] cnt);
    for (int i = 0; i < nwords; i++) send_word(rand64(), 4'($urandom_range(15)), 1'b0);
    send_word(rand64(), cnt, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hash_queue.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hash_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected hash %h", hash_value_o);
      end else begin
        if (hash_value_o !== hash_queue[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("hash mismatch: expected %h actual %h", hash_queue[0], hash_value_o);
        end
        void'(hash_queue.pop_front());
      end
    end
  end

  task automatic test_directed();
    send_word(64'h0, 4'd0, 1'b1);
    for (int n = 1; n <= 15; n++) send_word(rand64(), 4'(n), 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_message(3, 4'd8);
    send_message(3, 4'd0);
    send_message(4, 4'd15);
    send_message(7, 4'd4);
    send_word('1, 4'hf, 1'b0);
    send_word(64'h0, 4'd0, 1'b0);
    send_word('1, 4'd8, 1'b1);
  endtask

  task automatic test_random(int unsigned nwords);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < nwords) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(9);
      send_message(len, 4'($urandom_range(15)));
      sent += len + 1;
    end
  endtask

  task automatic test_pause();
    send_message(5, 4'd3);
    wait_drained();
    send_message(2, 4'd8);
  endtask

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 17;
    recv_idle_pct = 61;
    clear_msg();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    send_idle_pct = 61;
    recv_idle_pct = 17;
    test_pause();
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && hash_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
